// ===== rtl/bounded_sorted_event_buffer_assert.svh =====
`ifndef BOUNDED_SORTED_EVENT_BUFFER_ASSERT_SVH
`define BOUNDED_SORTED_EVENT_BUFFER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define BSEB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bseb assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define BSEB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bseb assertion failed");

`endif

// ===== rtl/bseb_pkg.sv =====
package bseb_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 5;
   localparam int LEN_W  = 5;
   localparam int TS_W   = 32;
   localparam int SID_W  = 8;
   localparam int VAL_W  = 16;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRIME,
      ST_INS_DN,
      ST_EV_HEAD,
      ST_EV_UP,
      ST_DEL_SEEK,
      ST_DEL_SHIFT,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      WA_HERE,
      WA_ABOVE,
      WA_BELOW
   } wa_sel_type;

   typedef struct packed {
      logic       load;
      logic       idx_zero;
      logic       idx_top;
      logic       idx_step;
      logic       idx_up;
      logic       wr_en;
      logic       wr_new;
      wa_sel_type wa_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       set_ok;
      logic       ev_head;
      logic       ev_self;
   } dp_cmd_type;

   typedef struct packed {
      logic is_delete;
      logic cap_zero;
      logic full;
      logic empty;
      logic time_gt;
      logic sid_eq;
      logic at_top;
      logic at_bottom;
   } dp_sts_type;

endpackage

// ===== rtl/bseb_ctrl.sv =====
module bseb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bseb_pkg::dp_sts_type sts,
   output bseb_pkg::dp_cmd_type cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import bseb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            if (sts.is_delete) begin
               if (sts.empty) begin
                  state_in = ST_RESP;
               end else begin
                  cmd.idx_zero = 1'b1;
                  state_in     = ST_DEL_SEEK;
               end
            end else if (sts.cap_zero) begin
               state_in = ST_RESP;
            end else if (sts.full) begin
               cmd.set_ok   = 1'b1;
               cmd.idx_zero = 1'b1;
               state_in     = ST_EV_HEAD;
            end else begin
               cmd.set_ok  = 1'b1;
               cmd.cnt_inc = 1'b1;
               if (sts.empty) begin
                  cmd.idx_zero = 1'b1;
                  state_in     = ST_FILL;
               end else begin
                  cmd.idx_top = 1'b1;
                  state_in    = ST_INS_DN;
               end
            end
         end
         ST_INS_DN: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_ABOVE;
            if (sts.time_gt) begin
               if (sts.at_bottom) begin
                  state_in = ST_FILL;
               end else begin
                  cmd.idx_step = 1'b1;
               end
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_EV_HEAD: begin
            if (sts.time_gt) begin
               cmd.ev_self = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.ev_head = 1'b1;
               if (sts.at_top) begin
                  state_in = ST_FILL;
               end else begin
                  cmd.idx_step = 1'b1;
                  cmd.idx_up   = 1'b1;
                  state_in     = ST_EV_UP;
               end
            end
         end
         ST_EV_UP: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_BELOW;
            if (sts.time_gt) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_RESP;
            end else if (sts.at_top) begin
               state_in = ST_FILL;
            end else begin
               cmd.idx_step = 1'b1;
               cmd.idx_up   = 1'b1;
            end
         end
         ST_DEL_SEEK: begin
            if (sts.sid_eq) begin
               cmd.set_ok = 1'b1;
               if (sts.at_top) begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  cmd.idx_step = 1'b1;
                  cmd.idx_up   = 1'b1;
                  state_in     = ST_DEL_SHIFT;
               end
            end else if (sts.at_top) begin
               state_in = ST_RESP;
            end else begin
               cmd.idx_step = 1'b1;
               cmd.idx_up   = 1'b1;
            end
         end
         ST_DEL_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_BELOW;
            if (sts.at_top) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.idx_step = 1'b1;
               cmd.idx_up   = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.wa_sel = WA_HERE;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ===== rtl/bseb_dp.sv =====
module bseb_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  bseb_pkg::dp_cmd_type              cmd,
   output bseb_pkg::dp_sts_type              sts,
   input  logic                              csr_wr_en,
   input  logic [bseb_pkg::CAP_W-1:0]        csr_wr_data,
   input  logic                              req_func,
   input  logic [bseb_pkg::TS_W-1:0]         req_timestamp,
   input  logic [bseb_pkg::SID_W-1:0]        req_sensor_id,
   input  logic signed [bseb_pkg::VAL_W-1:0] req_reading,
   output logic                              rsp_ok,
   output logic                              rsp_evicted,
   output logic [bseb_pkg::TS_W-1:0]         rsp_evicted_timestamp,
   output logic [bseb_pkg::LEN_W-1:0]        rsp_length
);
   import bseb_pkg::*;

   logic [TS_W-1:0]         time_mem_ff   [DEPTH];
   logic [SID_W-1:0]        sensor_mem_ff [DEPTH];
   logic signed [VAL_W-1:0] value_mem_ff  [DEPTH];

   logic [TS_W-1:0]         rd_time_ff;
   logic [SID_W-1:0]        rd_sensor_ff;
   logic signed [VAL_W-1:0] rd_value_ff;

   logic                    op_func_ff;
   logic [TS_W-1:0]         op_ts_ff;
   logic [SID_W-1:0]        op_sid_ff;
   logic signed [VAL_W-1:0] op_val_ff;

   logic [CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [ADDR_W-1:0] cidx_ff;
   logic [ADDR_W-1:0] cidx_in;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  cnt_m1;
   logic [ADDR_W-1:0] top_idx;
   logic [CMP_W-1:0]  cap_eff;

   logic                    ok_ff;
   logic                    ev_ff;
   logic [TS_W-1:0]         evts_ff;

   logic [TS_W-1:0]         wr_time;
   logic [SID_W-1:0]        wr_sensor;
   logic signed [VAL_W-1:0] wr_value;

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign top_idx = cnt_m1[ADDR_W-1:0];
   assign cap_eff = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                         : CMP_W'(capacity_ff);

   always_comb begin
      priority if (cmd.idx_zero) begin
         cidx_in = '0;
      end else if (cmd.idx_top) begin
         cidx_in = top_idx;
      end else if (cmd.idx_step) begin
         cidx_in = cmd.idx_up ? (cidx_ff + ADDR_W'(1)) : (cidx_ff - ADDR_W'(1));
      end else begin
         cidx_in = cidx_ff;
      end
   end

   always_comb begin
      unique case (cmd.wa_sel)
         WA_HERE:  wr_addr = cidx_ff;
         WA_ABOVE: wr_addr = cidx_ff + ADDR_W'(1);
         WA_BELOW: wr_addr = cidx_ff - ADDR_W'(1);
         default:  wr_addr = cidx_ff;
      endcase
   end

   assign wr_time   = cmd.wr_new ? op_ts_ff  : rd_time_ff;
   assign wr_sensor = cmd.wr_new ? op_sid_ff : rd_sensor_ff;
   assign wr_value  = cmd.wr_new ? op_val_ff : rd_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         time_mem_ff[wr_addr]   <= wr_time;
         sensor_mem_ff[wr_addr] <= wr_sensor;
         value_mem_ff[wr_addr]  <= wr_value;
      end
      rd_time_ff   <= time_mem_ff[cidx_in];
      rd_sensor_ff <= sensor_mem_ff[cidx_in];
      rd_value_ff  <= value_mem_ff[cidx_in];
      cidx_ff      <= cidx_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_func_ff <= req_func;
         op_ts_ff   <= req_timestamp;
         op_sid_ff  <= req_sensor_id;
         op_val_ff  <= req_reading;
      end
   end

   always_comb begin
      priority if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         count_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ok_ff   <= 1'b0;
         ev_ff   <= 1'b0;
         evts_ff <= '0;
      end else begin
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.ev_head) begin
            ev_ff   <= 1'b1;
            evts_ff <= rd_time_ff;
         end else if (cmd.ev_self) begin
            ev_ff   <= 1'b1;
            evts_ff <= op_ts_ff;
         end
      end
   end

   assign sts.is_delete = (op_func_ff == FUNC_DELETE);
   assign sts.cap_zero  = (capacity_ff == '0);
   assign sts.full      = (CMP_W'(count_ff) >= cap_eff);
   assign sts.empty     = (count_ff == '0);
   assign sts.time_gt   = (rd_time_ff > op_ts_ff);
   assign sts.sid_eq    = (rd_sensor_ff == op_sid_ff);
   assign sts.at_top    = (cidx_ff == top_idx);
   assign sts.at_bottom = (cidx_ff == '0);

   assign rsp_ok                = ok_ff;
   assign rsp_evicted           = ev_ff;
   assign rsp_evicted_timestamp = evts_ff;
   assign rsp_length            = LEN_W'(count_ff);

endmodule

// ===== rtl/bounded_sorted_event_buffer.sv =====
// One item at a time; busy stays high through the strobe cycle, and the walk over the
// table moves one entry per cycle.
// Results go out for one cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous): table empty, capacity 16; entry storage is not cleared.
module bounded_sorted_event_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [bseb_pkg::TS_W-1:0]         req_timestamp,
   input  logic [bseb_pkg::SID_W-1:0]        req_sensor_id,
   input  logic signed [bseb_pkg::VAL_W-1:0] req_reading,
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic                              rsp_evicted,
   output logic [bseb_pkg::TS_W-1:0]         rsp_evicted_timestamp,
   output logic [bseb_pkg::LEN_W-1:0]        rsp_length,
   input  logic                              csr_wr_en,
   input  logic [bseb_pkg::CAP_W-1:0]        csr_wr_data
);
   import bseb_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   bseb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bseb_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_func              (req_func),
      .req_timestamp         (req_timestamp),
      .req_sensor_id         (req_sensor_id),
      .req_reading           (req_reading),
      .rsp_ok                (rsp_ok),
      .rsp_evicted           (rsp_evicted),
      .rsp_evicted_timestamp (rsp_evicted_timestamp),
      .rsp_length            (rsp_length)
   );

endmodule

// ===== rtl/bseb_checker.sv =====
`include "bounded_sorted_event_buffer_assert.svh"

module bseb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic                      rsp_ok,
   input logic                      rsp_evicted,
   input logic [bseb_pkg::TS_W-1:0] rsp_evicted_timestamp
);
   import bseb_pkg::*;

   `BSEB_ASSERT_IMP(a_evict_needs_ok, clock, reset, rsp_valid && rsp_evicted, rsp_ok)
   `BSEB_ASSERT_IMP(a_no_evict_zero_ts, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_timestamp == '0)
   `BSEB_ASSERT_IMP(a_strobe_while_busy, clock, reset, rsp_valid, busy)
   `BSEB_ASSERT_NXT(a_strobe_ends_item, clock, reset, rsp_valid, !rsp_valid && !busy)
   `BSEB_ASSERT_NXT(a_start_sets_busy, clock, reset, start && !busy, busy)

endmodule

bind bounded_sorted_event_buffer bseb_checker u_bseb_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_ok                (rsp_ok),
   .rsp_evicted           (rsp_evicted),
   .rsp_evicted_timestamp (rsp_evicted_timestamp)
);

// ===== bench/event_buffer_checker.sv =====
`timescale 1ns / 1ps
module event_buffer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_func,
   input  logic [bseb_pkg::TS_W-1:0]          req_timestamp,
   input  logic [bseb_pkg::SID_W-1:0]         req_sensor_id,
   input  logic signed [bseb_pkg::VAL_W-1:0]  req_reading,
   input  logic                               rsp_valid,
   input  logic                               rsp_ok,
   input  logic                               rsp_evicted,
   input  logic [bseb_pkg::TS_W-1:0]          rsp_evicted_timestamp,
   input  logic [bseb_pkg::LEN_W-1:0]         rsp_length,
   input  logic                               csr_wr_en,
   input  logic [bseb_pkg::CAP_W-1:0]         csr_wr_data,
   output int                                 errors,
   output int                                 waiting,
   output int                                 n_insert,
   output int                                 n_delete,
   output int                                 n_evict,
   output int                                 n_miss
);
   import bseb_pkg::*;

   typedef struct packed {
      logic              ok;
      logic              evicted;
      logic [TS_W-1:0]   evicted_ts;
      logic [LEN_W-1:0]  length;
   } status_type;

   logic [TS_W-1:0]         slot_time    [DEPTH+1];
   logic [SID_W-1:0]        slot_sensor  [DEPTH+1];
   logic signed [VAL_W-1:0] slot_reading [DEPTH+1];
   int                      held;
   logic [CAP_W-1:0]        cap_reg;
   status_type              pending_status [$];

   function automatic void remove_entry(input int at);
      for (int i = at; i + 1 < held; i++) begin
         slot_time[i]    = slot_time[i+1];
         slot_sensor[i]  = slot_sensor[i+1];
         slot_reading[i] = slot_reading[i+1];
      end
      held--;
   endfunction

   function automatic status_type predict_event_op(input logic op,
                                                   input logic [TS_W-1:0] ts,
                                                   input logic [SID_W-1:0] sid,
                                                   input logic signed [VAL_W-1:0] rd);
      status_type r;
      int         limit;
      int         pos;
      bit         hit;
      r = '0;
      limit = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
      if (op == FUNC_INSERT) begin
         if (limit != 0) begin
            pos = 0;
            while (pos < held && slot_time[pos] <= ts)
               pos++;
            for (int i = held; i > pos; i--) begin
               slot_time[i]    = slot_time[i-1];
               slot_sensor[i]  = slot_sensor[i-1];
               slot_reading[i] = slot_reading[i-1];
            end
            slot_time[pos]    = ts;
            slot_sensor[pos]  = sid;
            slot_reading[pos] = rd;
            held++;
            r.ok = 1'b1;
            if (held > limit) begin
               r.evicted    = 1'b1;
               r.evicted_ts = slot_time[0];
               remove_entry(0);
            end
         end
      end else begin
         hit = 1'b0;
         for (int i = 0; i < held && !hit; i++) begin
            if (slot_sensor[i] == sid) begin
               remove_entry(i);
               r.ok = 1'b1;
               hit  = 1'b1;
            end
         end
      end
      r.length = LEN_W'(held);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [TS_W-1:0] want,
                                  input logic [TS_W-1:0] got);
      $display("checker: %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         held    = 0;
         cap_reg = CAP_RESET;
         pending_status.delete();
      end else begin
         if (csr_wr_en)
            cap_reg = csr_wr_data;
         if (rsp_valid) begin
            got = '{rsp_ok, rsp_evicted, rsp_evicted_timestamp, rsp_length};
            if (pending_status.size() == 0) begin
               report_mismatch("result with nothing pending", 0, 1);
            end else begin
               want = pending_status.pop_front();
               if (got.ok !== want.ok)
                  report_mismatch("ok", want.ok, got.ok);
               if (got.evicted !== want.evicted)
                  report_mismatch("evicted", want.evicted, got.evicted);
               if (got.evicted_ts !== want.evicted_ts)
                  report_mismatch("evicted_timestamp", want.evicted_ts, got.evicted_ts);
               if (got.length !== want.length)
                  report_mismatch("length", want.length, got.length);
            end
         end
         if (start && !busy) begin
            want = predict_event_op(req_func, req_timestamp, req_sensor_id, req_reading);
            pending_status.push_back(want);
            if (req_func == FUNC_INSERT) begin
               n_insert++;
               if (want.evicted)
                  n_evict++;
            end else begin
               n_delete++;
               if (!want.ok)
                  n_miss++;
            end
         end
      end
      waiting <= pending_status.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import bseb_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_func;
   logic [TS_W-1:0]          req_timestamp;
   logic [SID_W-1:0]         req_sensor_id;
   logic signed [VAL_W-1:0]  req_reading;
   logic                     rsp_valid;
   logic                     rsp_ok;
   logic                     rsp_evicted;
   logic [TS_W-1:0]          rsp_evicted_timestamp;
   logic [LEN_W-1:0]         rsp_length;
   logic                     csr_wr_en;
   logic [CAP_W-1:0]         csr_wr_data;

   int errors;
   int waiting;
   int n_insert;
   int n_delete;
   int n_evict;
   int n_miss;
   int idle_cycles;

   logic [CAP_W-1:0] phase_cap [8];

   bounded_sorted_event_buffer dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_timestamp         (req_timestamp),
      .req_sensor_id         (req_sensor_id),
      .req_reading           (req_reading),
      .rsp_valid             (rsp_valid),
      .rsp_ok                (rsp_ok),
      .rsp_evicted           (rsp_evicted),
      .rsp_evicted_timestamp (rsp_evicted_timestamp),
      .rsp_length            (rsp_length),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   event_buffer_checker u_check (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_timestamp         (req_timestamp),
      .req_sensor_id         (req_sensor_id),
      .req_reading           (req_reading),
      .rsp_valid             (rsp_valid),
      .rsp_ok                (rsp_ok),
      .rsp_evicted           (rsp_evicted),
      .rsp_evicted_timestamp (rsp_evicted_timestamp),
      .rsp_length            (rsp_length),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .errors                (errors),
      .waiting               (waiting),
      .n_insert              (n_insert),
      .n_delete              (n_delete),
      .n_evict               (n_evict),
      .n_miss                (n_miss)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   task automatic send(input logic op, input logic [TS_W-1:0] ts,
                       input logic [SID_W-1:0] sid, input logic [VAL_W-1:0] rd,
                       input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start         <= 1'b1;
      req_func      <= op;
      req_timestamp <= ts;
      req_sensor_id <= sid;
      req_reading   <= rd;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle;
      @(negedge clock);
      start <= 1'b0;
      while (waiting != 0 || busy) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random(input int gap_pct, input logic [SID_W-1:0] sid_base);
      logic             op;
      logic [TS_W-1:0]  ts;
      logic [SID_W-1:0] sid;
      int               pick;
      int               gap;
      op   = ($urandom_range(99) < 60) ? FUNC_INSERT : FUNC_DELETE;
      pick = $urandom_range(9);
      if (pick < 4)
         ts = $urandom_range(15);
      else if (pick < 8)
         ts = $urandom;
      else if (pick == 8)
         ts = '0;
      else
         ts = '1;
      if ($urandom_range(99) < 85)
         sid = sid_base + SID_W'($urandom_range(5));
      else
         sid = SID_W'($urandom);
      gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 7) : 0;
      send(op, ts, sid, VAL_W'($urandom), gap);
   endtask

   initial begin
      int               items;
      int               gap_pct;
      logic [SID_W-1:0] sid_base;
      reset         = 1'b1;
      start         = 1'b0;
      req_func      = FUNC_INSERT;
      req_timestamp = '0;
      req_sensor_id = '0;
      req_reading   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      phase_cap     = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd2, 5'd16, 5'd9};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(FUNC_DELETE, '0, 8'h00, 16'h0000, 0);
      send(FUNC_INSERT, 32'd100, 8'h01, 16'h0001, 0);
      send(FUNC_INSERT, 32'd100, 8'h02, 16'h7fff, 0);
      send(FUNC_INSERT, '0, 8'hff, 16'h8000, 0);
      send(FUNC_INSERT, '1, 8'h80, 16'hffff, 0);
      send(FUNC_DELETE, '0, 8'h02, 16'h0000, 0);
      send(FUNC_DELETE, '1, 8'h55, 16'hffff, 0);
      for (int i = 0; i < 13; i++)
         send(FUNC_INSERT, 32'd200 + i, 8'h10 + SID_W'(i), VAL_W'($urandom), 0);
      send(FUNC_INSERT, 32'd300, 8'h30, 16'h1234, 0);
      send(FUNC_INSERT, 32'd5, 8'h31, 16'h4321, 0);
      write_capacity(5'd0);
      send(FUNC_INSERT, 32'd50, 8'h32, 16'h0f0f, 0);
      write_capacity(5'd2);
      send(FUNC_INSERT, 32'd400, 8'h33, 16'hf0f0, 0);
      send(FUNC_DELETE, '0, 8'h10, 16'h0000, 0);

      for (int p = 0; p < 8; p++) begin
         write_capacity(phase_cap[p]);
         items    = (phase_cap[p] == 0) ? 60 : 270;
         sid_base = SID_W'($urandom);
         for (int n = 0; n < items; n++) begin
            gap_pct = (p < 7 && n < items / 2) ? 30 : 0;
            send_random(gap_pct, sid_base);
         end
      end

      settle();
      repeat (DEPTH + 8) @(negedge clock);
      $display("tb: %0d inserts (%0d evicting), %0d deletes (%0d missing)",
               n_insert, n_evict, n_delete, n_miss);
      $display("tb: capacities 0, 1, 2, 5, 9, 16 and 31, timestamp ties and extremes");
      if (errors == 0 && waiting == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bseb_pkg.sv
rtl/bseb_ctrl.sv
rtl/bseb_dp.sv
rtl/bounded_sorted_event_buffer.sv
rtl/bseb_checker.sv
bench/event_buffer_checker.sv
bench/tb.sv
